// File: sv/priority_queue_sorted_assert.svh
// Assertion macros for the sorted priority queue.
// Expect clk and arst_n in the scope of use.
`ifndef PRIORITY_QUEUE_SORTED_ASSERT_SVH
`define PRIORITY_QUEUE_SORTED_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PQS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pqs_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies.
package pqs_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 2;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                     out_valid;
		logic signed [DATA_W-1:0] out_value;
		logic signed [DATA_W-1:0] out_priority;
		logic [STATUS_W-1:0]      status;
	} result_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_CMP  = 7'b0000100,
		S_INS  = 7'b0001000,
		S_DRD  = 7'b0010000,
		S_DDAT = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

endpackage

// File: sv/pqs_chan_if.sv
// Request and response channels of the sorted priority queue.
// Depends on pqs_pkg.
interface pqs_req_if import pqs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] item_priority;

	modport source (output valid, func, item_value, item_priority, input ready);
	modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

interface pqs_rsp_if import pqs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     out_valid;
	logic signed [DATA_W-1:0] out_value;
	logic signed [DATA_W-1:0] out_priority;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, out_valid, out_value, out_priority, status, input ready);
	modport sink   (input valid, out_valid, out_value, out_priority, status, output ready);
endinterface

// File: sv/pqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pqs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/priority_queue_sorted.sv
// Enqueue: walks from the tail toward the head, reading and comparing each entry and moving each entry of lower
// priority back one slot, then writes the new word; an empty queue skips the walk.
// Dequeue reads the head entry; an empty dequeue or a full enqueue skips the RAM; an unaccepted response adds its wait.
// One request at a time; the read-compare-write walk through the single RAM port sets the rate.
// Async reset empties the queue and clears the sequencer and the response valid flag.
module priority_queue_sorted import pqs_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic     clk,
	input logic     arst_n,
	pqs_req_if.sink   req,
	pqs_rsp_if.source rsp
);

	`include "priority_queue_sorted_assert.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t          state_q;
	logic [AW-1:0]   head_q, tail_q, pos_q;
	logic [CW-1:0]   count_q, rem_q;
	entry_t          new_q;
	result_t         res_q;
	logic            ov_q;
	result_t         out_q;

	logic            wr_en, rd_en;
	logic [AW-1:0]   wr_addr, rd_addr;
	entry_t          wr_data, rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	logic [AW-1:0]   pos_dec, head_inc, tail_inc;
	logic            ge;
	logic            req_acc, out_free;

	pqs_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_entry = entry_t'(rd_data);
	assign pos_dec  = (pos_q == '0) ? AW'(CAPACITY - 1) : pos_q - 1'b1;
	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == AW'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;
	assign ge       = rd_entry.prio >= new_q.prio;
	assign req_acc  = req.valid && req.ready;
	assign out_free = !ov_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = rd_entry;
		rd_en   = 1'b0;
		rd_addr = pos_dec;
		case (state_q)
			S_RD: begin
				rd_en = 1'b1;
			end
			S_CMP: begin
				wr_en = !ge;
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_data = new_q;
			end
			S_DRD: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				ov_q <= 1'b1;
			end else if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.func == FUNC_ENQ) begin
							if (count_q == CW'(CAPACITY)) begin
								state_q <= S_FIN;
							end else if (count_q == '0) begin
								state_q <= S_INS;
							end else begin
								state_q <= S_RD;
							end
						end else if (count_q == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DRD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (ge || rem_q == CW'(1)) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_RD;
					end
				end
				S_INS: begin
					tail_q  <= tail_inc;
					count_q <= count_q + 1'b1;
					state_q <= S_FIN;
				end
				S_DRD: begin
					state_q <= S_DDAT;
				end
				S_DDAT: begin
					head_q  <= head_inc;
					count_q <= count_q - 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				new_q.value        <= req.item_value;
				new_q.prio         <= req.item_priority;
				pos_q              <= tail_q;
				rem_q              <= count_q;
				res_q.out_valid    <= 1'b0;
				res_q.out_value    <= '0;
				res_q.out_priority <= '0;
				if (req.func == FUNC_ENQ && count_q == CW'(CAPACITY)) begin
					res_q.status <= STATUS_FULL;
				end else if (req.func == FUNC_DEQ && count_q == '0) begin
					res_q.status <= STATUS_EMPTY;
				end else begin
					res_q.status <= STATUS_OK;
				end
			end
			S_CMP: begin
				if (!ge) begin
					pos_q <= pos_dec;
					rem_q <= rem_q - 1'b1;
				end
			end
			S_DDAT: begin
				res_q.out_valid    <= 1'b1;
				res_q.out_value    <= rd_entry.value;
				res_q.out_priority <= rd_entry.prio;
				res_q.status       <= STATUS_OK;
			end
			S_FIN: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = ov_q;
	assign rsp.out_valid    = out_q.out_valid;
	assign rsp.out_value    = out_q.out_value;
	assign rsp.out_priority = out_q.out_priority;
	assign rsp.status       = out_q.status;

	`PQS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "occupancy above capacity")
	`PQS_ASSERT_NOW(a_walk_rem, (state_q == S_RD) || (state_q == S_CMP), rem_q != '0, "walk past head")
	`PQS_ASSERT_NEXT(a_ins_count, state_q == S_INS, count_q == $past(count_q) + 1'b1, "insert lost")
	`PQS_ASSERT_NOW(a_deq_ok, rsp.valid && rsp.out_valid, rsp.status == STATUS_OK, "bad dequeue status")
	`PQS_ASSERT_NOW(a_busy, state_q != S_IDLE, !req.ready, "request taken while busy")

endmodule
